/* rtl/tgi_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the trajectory gap interpolator.
// Used by every module under rtl except tgi_div; depends on nothing.
package tgi_pkg;

    localparam int TIME_W       = 17;
    localparam int COORD_W      = 14;
    localparam int IV_W         = 12;
    localparam int MAX_FILL_DEF = 63;
    localparam int MAX_FILL_TOP = 63;
    localparam int N_W          = $clog2(MAX_FILL_TOP + 2);
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [IV_W-1:0] IV_RESET = IV_W'(30);

    typedef struct packed {
        logic [TIME_W-1:0]  fix_time;
        logic [COORD_W-1:0] fix_x;
        logic [COORD_W-1:0] fix_y;
        logic               first_of_day;
    } t_in;

    typedef struct packed {
        logic [TIME_W-1:0]  out_time;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               is_filled;
        logic               gap_overflow;
        logic               last_of_run;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0]  prev_time;
        logic [COORD_W-1:0] prev_x;
        logic [COORD_W-1:0] prev_y;
        logic [TIME_W-1:0]  fix_time;
        logic [COORD_W-1:0] fix_x;
        logic [COORD_W-1:0] fix_y;
        logic [N_W-1:0]     slots;
        logic               gap_overflow;
    } t_cmd;

endpackage

/* rtl/trajectory_gap_interpolator_unit.sv */
`timescale 1ns / 1ps
// Trajectory gap interpolator, top level.
// Depends on tgi_pkg, tgi_front, tgi_queue, tgi_back, tgi_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one fix per
//   transaction. Output channel (o_out_valid / i_out_ready / o_out_data)
//   carries the filled points of a gap, then the fix itself with
//   last_of_run set. i_cfg_we writes i_cfg_wdata into the sample interval.
//   Sequence:
//   - Front end takes a fix, divides the gap by the interval when a fill
//     is possible, then queues the command; it takes no new fix until then.
//   - Back end takes a command, divides the coordinate deltas by the slot
//     count when there are points to fill, then gives one output per cycle
//     while the output is not stalled: up to 63 filled points and the fix.
//   - Back end takes no new command until it has emitted the current fix.
//   Reset clears the previous fix (none held), empties the queue and sets
//   the interval to 30. A stalled receiver holds the output register; the
//   back end then stops, the queue fills and the input stalls in turn.
module trajectory_gap_interpolator_unit #(
    parameter int MAX_FILL = tgi_pkg::MAX_FILL_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  tgi_pkg::t_in             i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output tgi_pkg::t_out            o_out_data,
    input  logic                     i_cfg_we,
    input  logic [tgi_pkg::IV_W-1:0] i_cfg_wdata
);
    import tgi_pkg::*;

    logic [IV_W-1:0] r_interval;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    t_cmd            cmd_in;
    t_cmd            cmd_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= IV_RESET;
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_wdata;
        end
    end

    tgi_front #(
        .MAX_FILL(MAX_FILL)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_interval (r_interval),
        .o_push     (push),
        .o_cmd      (cmd_in),
        .i_full     (full)
    );

    tgi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (cmd_head),
        .o_empty (empty)
    );

    tgi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (cmd_head),
        .o_pop       (pop),
        .i_interval  (r_interval),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/tgi_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; no package dependencies.
module tgi_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

/* rtl/tgi_front.sv */
`timescale 1ns / 1ps
// Front end: accepts fixes, keeps the previous fix, sizes the gap in slots.
// Depends on tgi_pkg and tgi_div.
module tgi_front #(
    parameter int MAX_FILL = tgi_pkg::MAX_FILL_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tgi_pkg::t_in              i_in_data,
    input  logic [tgi_pkg::IV_W-1:0]  i_interval,
    output logic                      o_push,
    output tgi_pkg::t_cmd             o_cmd,
    input  logic                      i_full
);
    import tgi_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;

    localparam logic [TIME_W-1:0] FILL_LIM = TIME_W'(MAX_FILL + 1);

    t_state             r_state;
    t_cmd               r_cmd;
    logic [TIME_W-1:0]  r_prev_time;
    logic [COORD_W-1:0] r_prev_x;
    logic [COORD_W-1:0] r_prev_y;
    logic               r_have_prev;

    logic [TIME_W:0]    gap;
    logic               fill_cand;
    logic               accept;
    logic               div_start;
    logic               div_done;
    logic [TIME_W-1:0]  div_quo;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign gap        = {1'b0, i_in_data.fix_time} - {1'b0, r_prev_time};
    assign fill_cand  = r_have_prev && !i_in_data.first_of_day && (i_interval != '0)
                        && !gap[TIME_W] && (gap[TIME_W-1:0] > TIME_W'(i_interval));
    assign div_start  = accept && fill_cand;

    tgi_div #(
        .NUM_W(TIME_W),
        .DEN_W(IV_W)
    ) u_gap_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (gap[TIME_W-1:0]),
        .i_den   (i_interval),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   ()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= '0;
            r_prev_time <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd.prev_time    <= r_prev_time;
                        r_cmd.prev_x       <= r_prev_x;
                        r_cmd.prev_y       <= r_prev_y;
                        r_cmd.fix_time     <= i_in_data.fix_time;
                        r_cmd.fix_x        <= i_in_data.fix_x;
                        r_cmd.fix_y        <= i_in_data.fix_y;
                        r_cmd.slots        <= '0;
                        r_cmd.gap_overflow <= 1'b0;
                        r_prev_time        <= i_in_data.fix_time;
                        r_prev_x           <= i_in_data.fix_x;
                        r_prev_y           <= i_in_data.fix_y;
                        r_have_prev        <= 1'b1;
                        r_state            <= fill_cand ? S_DIV : S_PUSH;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (div_quo > FILL_LIM) begin
                            r_cmd.gap_overflow <= 1'b1;
                        end else begin
                            r_cmd.slots <= div_quo[N_W-1:0];
                        end
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_cmd  = r_cmd;

endmodule

/* rtl/tgi_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on tgi_pkg.
module tgi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tgi_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output tgi_pkg::t_cmd o_head,
    output logic          o_empty
);
    import tgi_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");
`endif

endmodule

/* rtl/tgi_back.sv */
`timescale 1ns / 1ps
// Back end: expands one command into filled points and the closing fix.
// Depends on tgi_pkg and tgi_div.
module tgi_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  tgi_pkg::t_cmd            i_cmd,
    output logic                     o_pop,
    input  logic [tgi_pkg::IV_W-1:0] i_interval,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output tgi_pkg::t_out            o_out_data
);
    import tgi_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FILL, S_FIX} t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic               r_negx;
    logic               r_negy;
    logic [COORD_W-1:0] r_qdx;
    logic [COORD_W-1:0] r_qdy;
    logic [N_W-1:0]     r_rdx;
    logic [N_W-1:0]     r_rdy;
    logic [COORD_W-1:0] r_qx;
    logic [COORD_W-1:0] r_qy;
    logic [N_W-1:0]     r_rx;
    logic [N_W-1:0]     r_ry;
    logic [TIME_W-1:0]  r_time;
    logic [N_W-1:0]     r_idx;
    logic               r_out_valid;
    t_out               r_out;

    logic [COORD_W:0]   dx;
    logic [COORD_W:0]   dy;
    logic [COORD_W-1:0] magx;
    logic [COORD_W-1:0] magy;
    logic               start_fill;
    logic               div_done;
    logic [COORD_W-1:0] quo_x;
    logic [COORD_W-1:0] quo_y;
    logic [N_W-1:0]     rem_x;
    logic [N_W-1:0]     rem_y;
    logic               out_free;
    logic               emit;
    logic [N_W:0]       sx;
    logic [N_W:0]       sy;
    logic               wx;
    logic               wy;
    logic [N_W:0]       sx_red;
    logic [N_W:0]       sy_red;
    logic [COORD_W-1:0] qx_n;
    logic [COORD_W-1:0] qy_n;
    logic [TIME_W-1:0]  time_n;

    assign dx   = {1'b0, i_cmd.fix_x} - {1'b0, i_cmd.prev_x};
    assign dy   = {1'b0, i_cmd.fix_y} - {1'b0, i_cmd.prev_y};
    assign magx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    assign magy = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign start_fill = o_pop && (i_cmd.slots >= N_W'(2));

    tgi_div #(
        .NUM_W(COORD_W),
        .DEN_W(N_W)
    ) u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_fill),
        .i_num   (magx),
        .i_den   (i_cmd.slots),
        .o_done  (div_done),
        .o_quo   (quo_x),
        .o_rem   (rem_x)
    );

    tgi_div #(
        .NUM_W(COORD_W),
        .DEN_W(N_W)
    ) u_ydiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_fill),
        .i_num   (magy),
        .i_den   (i_cmd.slots),
        .o_done  (),
        .o_quo   (quo_y),
        .o_rem   (rem_y)
    );

    // advance d*i/n by d/n: whole part plus remainder carry
    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = out_free && ((r_state == S_FILL) || (r_state == S_FIX));
    assign sx       = {1'b0, r_rx} + {1'b0, r_rdx};
    assign sy       = {1'b0, r_ry} + {1'b0, r_rdy};
    assign wx       = sx >= {1'b0, r_cmd.slots};
    assign wy       = sy >= {1'b0, r_cmd.slots};
    assign sx_red   = wx ? sx - {1'b0, r_cmd.slots} : sx;
    assign sy_red   = wy ? sy - {1'b0, r_cmd.slots} : sy;
    assign qx_n     = r_qx + r_qdx + COORD_W'(wx);
    assign qy_n     = r_qy + r_qdy + COORD_W'(wy);
    assign time_n   = r_time + TIME_W'(i_interval);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cmd       <= '0;
            r_out       <= '0;
            r_negx      <= 1'b0;
            r_negy      <= 1'b0;
            r_qdx       <= '0;
            r_qdy       <= '0;
            r_rdx       <= '0;
            r_rdy       <= '0;
            r_qx        <= '0;
            r_qy        <= '0;
            r_rx        <= '0;
            r_ry        <= '0;
            r_time      <= '0;
            r_idx       <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_negx  <= dx[COORD_W];
                        r_negy  <= dy[COORD_W];
                        r_state <= start_fill ? S_DIV : S_FIX;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_qdx   <= quo_x;
                        r_qdy   <= quo_y;
                        r_rdx   <= rem_x;
                        r_rdy   <= rem_y;
                        r_qx    <= '0;
                        r_qy    <= '0;
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_time  <= r_cmd.prev_time;
                        r_idx   <= N_W'(1);
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (out_free) begin
                        r_qx   <= qx_n;
                        r_qy   <= qy_n;
                        r_rx   <= sx_red[N_W-1:0];
                        r_ry   <= sy_red[N_W-1:0];
                        r_time <= time_n;
                        r_out.out_time     <= time_n;
                        r_out.out_x        <= r_negx ? r_cmd.prev_x - qx_n
                                                     : r_cmd.prev_x + qx_n;
                        r_out.out_y        <= r_negy ? r_cmd.prev_y - qy_n
                                                     : r_cmd.prev_y + qy_n;
                        r_out.is_filled    <= 1'b1;
                        r_out.gap_overflow <= 1'b0;
                        r_out.last_of_run  <= 1'b0;
                        if (r_idx == r_cmd.slots - N_W'(1)) begin
                            r_state <= S_FIX;
                        end else begin
                            r_idx <= r_idx + N_W'(1);
                        end
                    end
                end
                S_FIX: begin
                    if (out_free) begin
                        r_out.out_time     <= r_cmd.fix_time;
                        r_out.out_x        <= r_cmd.fix_x;
                        r_out.out_y        <= r_cmd.fix_y;
                        r_out.is_filled    <= 1'b0;
                        r_out.gap_overflow <= r_cmd.gap_overflow;
                        r_out.last_of_run  <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> (r_rx < r_cmd.slots) && (r_ry < r_cmd.slots))
        else $error("interpolation remainder not below slot count");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> (r_cmd.slots >= N_W'(2)) && (r_idx < r_cmd.slots))
        else $error("fill index out of range");
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last_of_run |-> !r_out.is_filled)
        else $error("closing fix marked as filled");
    a_ovf_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.gap_overflow |-> r_out.last_of_run)
        else $error("overflow flag on a filled point");
`endif

endmodule

/* tb/sv/trajectory_gap_interpolator_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for trajectory_gap_interpolator_unit: drives fixes, predicts the
// gap-fill points in SystemVerilog and checks every output transaction in order.
// Depends on tgi_pkg and the RTL under rtl.
module trajectory_gap_interpolator_unit_tb;
    import tgi_pkg::*;

    localparam int FILL_LIMIT      = MAX_FILL_DEF;
    localparam int STALL_LIMIT     = 4000;
    localparam int PRESSURE_CYCLES = 600;
    localparam int PHASE_ITEMS     = 20;
    localparam int SETTLE_CYCLES   = 40;

    logic              i_clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in               in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out              out_data;
    logic              cfg_we = 1'b0;
    logic [IV_W-1:0]   cfg_wdata = '0;

    t_in               pending_fixes[$];
    t_out              expected_points[$];

    logic [TIME_W-1:0]  last_time = '0;
    logic [COORD_W-1:0] last_x = '0;
    logic [COORD_W-1:0] last_y = '0;
    logic               have_last = 1'b0;
    logic [IV_W-1:0]    interval_cfg = IV_RESET;
    logic [TIME_W-1:0]  stream_time = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    logic pressure_go = 1'b0;
    logic pressure_done = 1'b0;

    trajectory_gap_interpolator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void predict_points(input t_in f);
        int   gap;
        int   n;
        int   iv;
        int   dx;
        int   dy;
        int   i;
        t_out p;
        logic ovf;
        ovf = 1'b0;
        iv = int'(interval_cfg);
        if (have_last && !f.first_of_day && iv != 0) begin
            gap = int'(f.fix_time) - int'(last_time);
            if (gap > iv) begin
                n = gap / iv;
                if (n > FILL_LIMIT + 1) begin
                    ovf = 1'b1;
                end else begin
                    dx = int'(f.fix_x) - int'(last_x);
                    dy = int'(f.fix_y) - int'(last_y);
                    for (i = 1; i < n; i++) begin
                        p.out_time     = TIME_W'(int'(last_time) + iv * i);
                        p.out_x        = COORD_W'(int'(last_x) + (dx * i) / n);
                        p.out_y        = COORD_W'(int'(last_y) + (dy * i) / n);
                        p.is_filled    = 1'b1;
                        p.gap_overflow = 1'b0;
                        p.last_of_run  = 1'b0;
                        expected_points.push_back(p);
                    end
                end
            end
        end
        p.out_time     = f.fix_time;
        p.out_x        = f.fix_x;
        p.out_y        = f.fix_y;
        p.is_filled    = 1'b0;
        p.gap_overflow = ovf;
        p.last_of_run  = 1'b1;
        expected_points.push_back(p);
        last_time = f.fix_time;
        last_x    = f.fix_x;
        last_y    = f.fix_y;
        have_last = 1'b1;
    endfunction

    function automatic void check_point(input t_out got);
        t_out exp;
        if (expected_points.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected point: t=%0d x=%0d y=%0d", got.out_time, got.out_x,
                         got.out_y);
            return;
        end
        exp = expected_points.pop_front();
        if (got.out_time !== exp.out_time || got.out_x !== exp.out_x ||
            got.out_y !== exp.out_y || got.is_filled !== exp.is_filled ||
            got.gap_overflow !== exp.gap_overflow || got.last_of_run !== exp.last_of_run) begin
            fail_count++;
            if (fail_count <= 10) begin
                $write("mismatch: expected t=%0d x=%0d y=%0d f=%0b o=%0b l=%0b, ",
                       exp.out_time, exp.out_x, exp.out_y, exp.is_filled,
                       exp.gap_overflow, exp.last_of_run);
                $display("got t=%0d x=%0d y=%0d f=%0b o=%0b l=%0b",
                         got.out_time, got.out_x, got.out_y, got.is_filled,
                         got.gap_overflow, got.last_of_run);
            end
        end
    endfunction

    function automatic void queue_fix(input int t, input int x, input int y, input bit first);
        t_in f;
        f.fix_time     = TIME_W'(t);
        f.fix_x        = COORD_W'(x);
        f.fix_y        = COORD_W'(y);
        f.first_of_day = first;
        pending_fixes.push_back(f);
    endfunction

    function automatic t_in random_fix(input int iv);
        t_in         f;
        logic [63:0] raw;
        int          roll;
        int          slots;
        int          step;
        roll = $urandom_range(0, 99);
        step = (iv == 0) ? 30 : iv;
        if (roll < 12) begin
            raw = {$urandom(), $urandom()};
            f = raw[$bits(t_in)-1:0];
        end else begin
            if (roll < 22)
                slots = $urandom_range(60, 70);
            else
                slots = $urandom_range(0, 6);
            f.fix_time     = TIME_W'(int'(stream_time) + slots * step +
                                     $urandom_range(0, step - 1));
            f.fix_x        = COORD_W'($urandom_range(0, 12000));
            f.fix_y        = COORD_W'($urandom_range(0, 12000));
            f.first_of_day = ($urandom_range(0, 99) < 6);
        end
        stream_time = f.fix_time;
        return f;
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_fixes.size() != 0 || in_valid || expected_points.size() != 0);
    endtask

    task automatic write_interval(input int v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= IV_W'(v);
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        interval_cfg = IV_W'(v);
        @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                predict_points(in_data);
            if (!in_valid || in_ready) begin
                if (pending_fixes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_data  <= pending_fixes.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready)
                check_point(out_data);
            if (pressure_go && !pressure_done) begin
                pressure_done <= 1'b1;
                hold_left     <= PRESSURE_CYCLES;
                out_ready     <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int phase_iv[6];
        int ph;
        int k;
        phase_iv = '{1, 4095, 17, 0, 3600, 30};
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 22;
        recv_idle_pct = 62;
        queue_fix(100, 0, 0, 1'b0);
        queue_fix(130, 50, 60, 1'b0);
        queue_fix(190, 16383, 16383, 1'b0);
        queue_fix(190, 1, 2, 1'b0);
        queue_fix(40, 3, 4, 1'b0);
        queue_fix(85, 5, 6, 1'b0);
        queue_fix(2005, 0, 12000, 1'b0);
        queue_fix(3955, 12000, 0, 1'b0);
        queue_fix(4255, 12000, 3, 1'b1);
        queue_fix(4412, 7, 11999, 1'b0);
        queue_fix(131071, 10922, 5461, 1'b0);
        queue_fix(0, 5461, 10922, 1'b0);
        queue_fix(95, 16383, 0, 1'b0);
        queue_fix(2044, 0, 16383, 1'b0);
        queue_fix(86399, 12000, 12000, 1'b1);
        stream_time = TIME_W'(86399);
        wait_drained();

        for (ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 22;
                recv_idle_pct = 62;
            end else if (ph < 4) begin
                send_idle_pct = 62;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_interval(phase_iv[ph]);
            for (k = 0; k < PHASE_ITEMS; k++)
                pending_fixes.push_back(random_fix(phase_iv[ph]));
            if (ph == 5)
                pressure_go = 1'b1;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        fail_count += expected_points.size();
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
